>>> design/pal_pkg.sv
package pal_pkg;

    // Default sizing
    localparam int CAPACITY_DEF    = 512;
    localparam int ENTRY_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int REQ_W   = 2;
    localparam int POS_W   = 9;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 10;
    localparam int ERR_W   = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;
    localparam logic [ERR_W-1:0] ERR_POS   = 2'd3;

endpackage

>>> design/pal_ram.sv
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/positional_array_list_top.sv
// Ordered list of up to CAPACITY words held in one single-port-write,
// registered-read RAM, plus a count. Each item is an insert, remove or read at
// a list position; every item gives exactly one result item carrying the
// removed or read word (zero for an insert or an error), the count after the
// request, and an error code (full, empty, bad position). One item is worked
// at a time. An insert moves each entry from the last one down to position p
// up one place before writing the new word there, and a remove moves each
// entry above p down one place; a read or a rejected item moves nothing. Each
// moving entry goes one place per cycle through the RAM, read in one cycle and
// written back to its neighboring address in the next. The RAM content is
// undefined after reset and is never cleared; only entries below the count
// are ever read. The next item is accepted as soon as the current one is
// finished, even while its result still waits in the output register.
module positional_array_list_top #(
    parameter int CAPACITY    = pal_pkg::CAPACITY_DEF,
    parameter int ENTRY_WIDTH = pal_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [pal_pkg::REQ_W-1:0]   req_type,
    input  logic [pal_pkg::POS_W-1:0]   position,
    input  logic [pal_pkg::VALUE_W-1:0] entry_value,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [pal_pkg::VALUE_W-1:0] result_value,
    output logic [pal_pkg::COUNT_W-1:0] entry_count,
    output logic [pal_pkg::ERR_W-1:0]   error_code
);

    import pal_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int XW   = (ENTRY_WIDTH > VALUE_W) ? ENTRY_WIDTH : VALUE_W;
    localparam int TW   = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_PUT,
        S_FETCH,
        S_SHIFT_DOWN,
        S_DONE
    } state_t;

    state_t                 state_reg,  state_next;
    logic [AW-1:0]          cur_reg,    cur_next;
    logic [AW-1:0]          pos_reg,    pos_next;
    logic [REQ_W-1:0]       op_reg,     op_next;
    logic [ENTRY_WIDTH-1:0] word_reg,   word_next;
    logic [CW-1:0]          total_reg,  total_next;
    logic [ENTRY_WIDTH-1:0] value_reg,  value_next;
    logic [ERR_W-1:0]       err_reg,    err_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]     out_value_reg, out_value_next;
    logic [COUNT_W-1:0]     out_count_reg, out_count_next;
    logic [ERR_W-1:0]       out_err_reg,   out_err_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [ENTRY_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [ENTRY_WIDTH-1:0] ram_rdata;

    logic [CMPW-1:0]        pos_cmp;
    logic [CMPW-1:0]        total_cmp;
    logic [CW-1:0]          total_m1;
    logic [XW-1:0]          in_word_ext;
    logic [XW-1:0]          value_ext;
    logic [TW-1:0]          total_ext;
    logic                   accept;

    pal_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept      = in_valid && !in_stall;
    assign in_stall    = (state_reg != S_IDLE);
    assign pos_cmp     = CMPW'(position);
    assign total_cmp   = CMPW'(total_reg);
    assign total_m1    = total_reg - CW'(1);
    assign in_word_ext = XW'(entry_value);
    assign value_ext   = XW'(value_reg);
    assign total_ext   = TW'(total_reg);

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        op_next        = op_reg;
        word_next      = word_reg;
        total_next     = total_reg;
        value_next     = value_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_count_next = out_count_reg;
        out_err_next   = out_err_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = cur_reg;

        // Drop the delivered result
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req_type;
                    pos_next   = AW'(position);
                    word_next  = in_word_ext[ENTRY_WIDTH-1:0];
                    value_next = '0;
                    err_next   = ERR_OK;
                    state_next = S_DONE;
                    unique case (req_type)
                        REQ_INSERT:
                        begin
                            if (total_reg >= CW'(CAPACITY))
                            begin
                                err_next = ERR_FULL;
                            end
                            else if (pos_cmp > total_cmp)
                            begin
                                err_next = ERR_POS;
                            end
                            else if (pos_cmp == total_cmp)
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                // Start moving the tail up from the last entry
                                ram_re     = 1'b1;
                                ram_raddr  = total_m1[AW-1:0];
                                cur_next   = total_m1[AW-1:0];
                                state_next = S_SHIFT_UP;
                            end
                        end
                        REQ_REMOVE, REQ_READ:
                        begin
                            if (total_reg == '0)
                            begin
                                err_next = ERR_EMPTY;
                            end
                            else if (pos_cmp >= total_cmp)
                            begin
                                err_next = ERR_POS;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(position);
                                cur_next   = AW'(position);
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            err_next = ERR_POS;
                        end
                    endcase
                end
            end

            S_SHIFT_UP:
            begin
                // Write entry cur into cur+1, read the one below
                ram_we    = 1'b1;
                ram_waddr = cur_reg + AW'(1);
                if (cur_reg == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = cur_reg - AW'(1);
                    cur_next  = cur_reg - AW'(1);
                end
            end

            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = word_reg;
                total_next = total_reg + CW'(1);
                state_next = S_DONE;
            end

            S_FETCH:
            begin
                value_next = ram_rdata;
                state_next = S_DONE;
                if (op_reg == REQ_REMOVE)
                begin
                    total_next = total_m1;
                    if (CW'(pos_reg) < total_m1)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = pos_reg + AW'(1);
                        cur_next   = pos_reg + AW'(1);
                        state_next = S_SHIFT_DOWN;
                    end
                end
            end

            S_SHIFT_DOWN:
            begin
                // Write entry cur into cur-1, read the one above
                ram_we    = 1'b1;
                ram_waddr = cur_reg - AW'(1);
                if (CW'(cur_reg) == total_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = cur_reg + AW'(1);
                    cur_next  = cur_reg + AW'(1);
                end
            end

            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = value_ext[VALUE_W-1:0];
                    out_count_next = total_ext[COUNT_W-1:0];
                    out_err_next   = err_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        pos_reg       <= pos_next;
        op_reg        <= op_next;
        word_reg      <= word_next;
        value_reg     <= value_next;
        err_reg       <= err_next;
        out_value_reg <= out_value_next;
        out_count_reg <= out_count_next;
        out_err_reg   <= out_err_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign entry_count  = out_count_reg;
    assign error_code   = out_err_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE || state_reg == S_FETCH) |-> !ram_we)
        else $error("store written outside a shift or put step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_UP) |-> (cur_reg >= pos_reg))
        else $error("upward shift ran past the insert position");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_DOWN) |-> (CW'(cur_reg) <= total_reg))
        else $error("downward shift ran past the list end");

    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(total_reg) |-> ($past(state_reg) == S_PUT || $past(state_reg) == S_FETCH))
        else $error("entry count changed outside put or fetch");

endmodule

>>> bench/pal_list_checker.sv
module pal_list_checker #(
    parameter int CAPACITY    = pal_pkg::CAPACITY_DEF,
    parameter int ENTRY_WIDTH = pal_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [pal_pkg::REQ_W-1:0]   req_type,
    input  logic [pal_pkg::POS_W-1:0]   position,
    input  logic [pal_pkg::VALUE_W-1:0] entry_value,

    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [pal_pkg::VALUE_W-1:0] result_value,
    input  logic [pal_pkg::COUNT_W-1:0] entry_count,
    input  logic [pal_pkg::ERR_W-1:0]   error_code,

    output int                          mismatches,
    output int                          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import pal_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic [ERR_W-1:0]   err;
    } list_result_t;

    logic [ENTRY_WIDTH-1:0] list_words [CAPACITY];
    int                     list_len;
    list_result_t           expected_results [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
        list_len    = 0;
    end

    // Apply one request to the list copy and return the result it gives.
    function automatic list_result_t apply_request(
        input logic [REQ_W-1:0]   kind,
        input logic [POS_W-1:0]   pos,
        input logic [VALUE_W-1:0] word
    );
        list_result_t res;
        int           at;
        res = '0;
        at  = int'(pos);
        res.err = ERR_OK;
        case (kind)
            REQ_INSERT: begin
                if (list_len >= CAPACITY) begin
                    res.err = ERR_FULL;
                end else if (at > list_len) begin
                    res.err = ERR_POS;
                end else begin
                    for (int i = list_len; i > at; i--)
                        list_words[i] = list_words[i-1];
                    list_words[at] = ENTRY_WIDTH'(word);
                    list_len++;
                end
            end
            REQ_REMOVE, REQ_READ: begin
                if (list_len == 0) begin
                    res.err = ERR_EMPTY;
                end else if (at >= list_len || at >= CAPACITY) begin
                    res.err = ERR_POS;
                end else begin
                    res.value = VALUE_W'(list_words[at]);
                    if (kind == REQ_REMOVE) begin
                        list_len--;
                        for (int i = at; i < list_len; i++)
                            list_words[i] = list_words[i+1];
                    end
                end
            end
            default: res.err = ERR_POS;
        endcase
        res.count = COUNT_W'(list_len);
        return res;
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t ns: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n) begin
        list_result_t seen;
        list_result_t want;
        if (!rst_n) begin
            list_len = 0;
            expected_results.delete();
            outstanding = 0;
        end else begin
            // Compare the result item first; it never belongs to a request
            // taken at this same edge.
            if (out_valid && !out_stall) begin
                seen = {result_value, entry_count, error_code};
                if (expected_results.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected result: value=%h count=%0d err=%0d",
                        result_value, entry_count, error_code));
                end else begin
                    want = expected_results.pop_front();
                    if (seen.value !== want.value || seen.count !== want.count ||
                        seen.err !== want.err)
                        note_failure($sformatf(
                            {"result mismatch: exp value=%h count=%0d err=%0d, ",
                             "got value=%h count=%0d err=%0d"},
                            want.value, want.count, want.err,
                            seen.value, seen.count, seen.err));
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(apply_request(req_type, position, entry_value));
            outstanding = expected_results.size();
        end
    end

endmodule

>>> bench/positional_array_list_top_tb.sv
module positional_array_list_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pal_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int RESET_CYCLES = 11;
    // A request shifts at most CAPACITY entries, one per cycle, besides its fetch,
    // put and done steps; the quiet limit leaves ample room for stalls on top.
    localparam int QUIET_LIMIT  = 8 * CAPACITY;
    localparam int DRAIN_CYCLES = CAPACITY + 8;
    localparam int PHASES       = 4;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [REQ_W-1:0]   req_type;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] entry_value;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [VALUE_W-1:0] result_value;
    logic [COUNT_W-1:0] entry_count;
    logic [ERR_W-1:0]   error_code;

    int mismatches;
    int outstanding;

    // Percent chance per cycle that the sender holds off or the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;

    // Track only the list length, to steer positions toward valid ranges.
    int list_size = 0;

    int quiet_cycles = 0;

    positional_array_list_top #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (ENTRY_WIDTH_DEF)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .position     (position),
        .entry_value  (entry_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .entry_count  (entry_count),
        .error_code   (error_code)
    );

    pal_list_checker #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (ENTRY_WIDTH_DEF)
    ) list_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .position     (position),
        .entry_value  (entry_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .entry_count  (entry_count),
        .error_code   (error_code),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: abort if neither channel moves an item for too long.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Present one request item, hold it until accepted, and advance the
    // length tracker. Return at the falling edge after acceptance.
    task automatic send_request(
        input logic [REQ_W-1:0]   kind,
        input logic [POS_W-1:0]   pos,
        input logic [VALUE_W-1:0] word
    );
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        req_type    <= kind;
        position    <= pos;
        entry_value <= word;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        case (kind)
            REQ_INSERT:
                if (list_size < CAPACITY && int'(pos) <= list_size)
                    list_size++;
            REQ_REMOVE:
                if (list_size > 0 && int'(pos) < list_size)
                    list_size--;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Draw one random request. Most are well formed and steer the length
    // toward grow_to; the rest are noise over the full field ranges.
    task automatic send_random_request(input int grow_to);
        logic [REQ_W-1:0] kind;
        logic [POS_W-1:0] pos;
        int               span;
        int               roll;
        if ($urandom_range(9) == 0) begin
            kind = REQ_W'($urandom_range(3));
            pos  = POS_W'($urandom_range(511));
        end else begin
            roll = $urandom_range(99);
            if (list_size < grow_to)
                kind = (roll < 95) ? REQ_INSERT : (roll < 98) ? REQ_READ : REQ_REMOVE;
            else
                kind = (roll < 60) ? REQ_REMOVE : (roll < 80) ? REQ_READ : REQ_INSERT;
            // Inserts may land one past the last entry; removes and reads may not.
            if (kind == REQ_INSERT)
                span = list_size;
            else
                span = (list_size == 0) ? 0 : list_size - 1;
            if (span > 511)
                span = 511;
            case ($urandom_range(3))
                0:       pos = '0;
                1:       pos = POS_W'(span);
                default: pos = POS_W'($urandom_range(span));
            endcase
        end
        send_request(kind, pos, $urandom);
    endtask

    initial
    begin
        int phase_items [PHASES] = '{750, 150, 120, 80};
        int phase_idle  [PHASES] = '{0, 72, 0, 16};
        int phase_stall [PHASES] = '{0, 0, 72, 16};
        int phase_goal  [PHASES] = '{CAPACITY, 0, CAPACITY, 0};

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req_type    = REQ_INSERT;
        position    = '0;
        entry_value = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: errors on an empty list, then the ends and middle of a
        // short list, then drain it back to empty.
        send_request(REQ_READ,    9'd0,   32'h0000_0000);
        send_request(REQ_REMOVE,  9'd5,   32'h0000_0000);
        send_request(REQ_INSERT,  9'd1,   32'h1234_5678);
        send_request(REQ_UNUSED,  9'd0,   32'hFFFF_FFFF);
        send_request(REQ_INSERT,  9'd0,   32'hFFFF_FFFF);
        send_request(REQ_INSERT,  9'd1,   32'h0000_0000);
        send_request(REQ_INSERT,  9'd0,   32'hA5A5_A5A5);
        send_request(REQ_INSERT,  9'd1,   32'h5A5A_5A5A);
        send_request(REQ_READ,    9'd3,   32'hFFFF_FFFF);
        send_request(REQ_READ,    9'd4,   32'h0000_0000);
        send_request(REQ_READ,    9'd511, 32'h0000_0000);
        send_request(REQ_REMOVE,  9'd4,   32'h0000_0000);
        send_request(REQ_INSERT,  9'd511, 32'hDEAD_BEEF);
        send_request(REQ_UNUSED,  9'd511, 32'h0000_0000);
        send_request(REQ_READ,    9'd1,   32'h0000_0000);
        send_request(REQ_REMOVE,  9'd0,   32'h0000_0000);
        send_request(REQ_REMOVE,  9'd2,   32'h0000_0000);
        send_request(REQ_INSERT,  9'd2,   32'h8000_0001);
        send_request(REQ_REMOVE,  9'd1,   32'h0000_0000);
        send_request(REQ_READ,    9'd0,   32'h0000_0000);
        send_request(REQ_REMOVE,  9'd1,   32'h0000_0000);
        send_request(REQ_REMOVE,  9'd0,   32'h0000_0000);
        send_request(REQ_REMOVE,  9'd0,   32'h0000_0000);

        // Random phases: fill to capacity with no idling, then drain and
        // refill under sender gaps, receiver stalls, and both together.
        for (int ph = 0; ph < PHASES; ph++) begin
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            repeat (phase_items[ph])
                send_random_request(phase_goal[ph]);
        end
        in_valid <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;

        // Drain every expected result, then hold long enough for a stray one.
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
